FILE: hw/rtl/mdfr_pkg.sv
package mdfr_pkg;

  localparam int unsigned MTU    = 64;
  localparam int unsigned FLEN_W = $clog2(MTU + 1);
  localparam int unsigned CMP_W  = (FLEN_W > 7) ? FLEN_W : 7;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_MARK_BYTE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_FRAME_LEN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0] MARK_BYTE_RST     = 8'd126;
  localparam logic [6:0] MIN_FRAME_LEN_RST = 7'd3;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic OP_BYTE = 1'b0;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_GOOD     = 3'd2,
    EV_CRCERR   = 3'd3,
    EV_SHORT    = 3'd4,
    EV_OVERFLOW = 3'd5
  } evt_t;

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mark_delimited_frame_receiver.sv
// Mark-delimited frame receiver. Each input item is either a received byte
// (in_tuser = 0, byte in in_tdata) or a 1 ms tick (in_tuser = 1), and each item
// yields exactly one result item whose kind sits in out_tuser: none, byte stored,
// frame good, CRC error, too short or overflow restart. A lone mark byte closes
// the frame, a doubled mark is a literal mark, and a mark after the idle timeout
// closes the frame at once. The CRC-16 CCITT (init FFFF) over all but the last
// two bytes is checked against those bytes read as a little-endian FCS. Every
// item is handled by logic between the input handshake and the result register,
// so one item is taken per cycle whenever the result register is empty or being
// drained; the result is registered and appears in the cycle after acceptance.
// Configuration writes must only happen while the block is idle.
module mark_delimited_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_byte, byte_index, payload_length, frame_type
  output logic [2:0]  out_tuser   // event_res
);

  localparam int unsigned FW = mdfr_pkg::FLEN_W;
  localparam int unsigned CW = mdfr_pkg::CMP_W;

  logic [7:0] mark_byte_r;
  logic [6:0] min_frame_len_r;
  logic [7:0] timeout_ticks_r;

  logic          mark_pending_r, mark_pending_nxt;
  logic          idle_flag_r, idle_flag_nxt;
  logic [7:0]    idle_ticks_r, idle_ticks_nxt;
  logic [FW-1:0] frame_len_r, frame_len_nxt;
  logic [15:0]   running_crc_r, running_crc_nxt;
  logic [15:0]   last_two_r, last_two_nxt;
  logic [7:0]    first_byte_r, first_byte_nxt;

  logic             out_tvalid_r;
  mdfr_pkg::evt_t   ev_r, ev_nxt;
  logic [7:0]       dbyte_r, dbyte_nxt;
  logic [5:0]       idx_r, idx_nxt;
  logic [5:0]       plen_r, plen_nxt;
  logic [7:0]       ftype_r, ftype_nxt;

  logic          accept;
  logic          is_mark, first_mark, end_cond, too_short;
  logic [7:0]    ticks_inc;
  logic [FW-1:0] len_c;
  logic [15:0]   crc_c, l2_c, fcs;
  logic [CW-1:0] len_ext, min_ext, diff;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {4'd0, ftype_r, plen_r, idx_r, dbyte_r};

  always_comb begin
    mark_pending_nxt = mark_pending_r;
    idle_flag_nxt    = idle_flag_r;
    idle_ticks_nxt   = idle_ticks_r;
    frame_len_nxt    = frame_len_r;
    running_crc_nxt  = running_crc_r;
    last_two_nxt     = last_two_r;
    first_byte_nxt   = first_byte_r;
    ev_nxt           = mdfr_pkg::EV_NONE;
    dbyte_nxt        = 8'd0;
    idx_nxt          = 6'd0;
    plen_nxt         = 6'd0;
    ftype_nxt        = 8'd0;

    is_mark    = (in_tdata == mark_byte_r);
    first_mark = is_mark && !mark_pending_r;
    end_cond   = (first_mark || mark_pending_r) && (!is_mark || idle_flag_r);
    ticks_inc  = (idle_ticks_r != 8'hFF) ? idle_ticks_r + 8'd1 : idle_ticks_r;
    len_ext    = CW'(frame_len_r);
    min_ext    = CW'(min_frame_len_r);
    diff       = len_ext - min_ext;
    too_short  = (len_ext < min_ext) || (frame_len_r < FW'(2));
    fcs        = {last_two_r[7:0], last_two_r[15:8]};
    len_c      = frame_len_r;
    crc_c      = running_crc_r;
    l2_c       = last_two_r;

    if (in_tuser != mdfr_pkg::OP_BYTE) begin
      idle_ticks_nxt = ticks_inc;
      if (ticks_inc >= timeout_ticks_r) begin
        idle_flag_nxt = 1'b1;
      end
    end else if (first_mark && !idle_flag_r) begin
      mark_pending_nxt = 1'b1;
    end else begin
      if (end_cond) begin
        if (frame_len_r != '0) begin
          ftype_nxt = first_byte_r;
          if (too_short) begin
            ev_nxt = mdfr_pkg::EV_SHORT;
          end else begin
            ev_nxt   = (fcs == running_crc_r) ? mdfr_pkg::EV_GOOD : mdfr_pkg::EV_CRCERR;
            plen_nxt = diff[5:0];
          end
        end
        len_c = '0;
        crc_c = mdfr_pkg::CRC_INIT;
        l2_c  = 16'd0;
      end
      if (end_cond && is_mark) begin
        mark_pending_nxt = 1'b0;
        frame_len_nxt    = len_c;
        running_crc_nxt  = crc_c;
        last_two_nxt     = l2_c;
      end else begin
        mark_pending_nxt = 1'b0;
        idle_flag_nxt    = 1'b0;
        idle_ticks_nxt   = 8'd0;
        if (len_c >= FW'(mdfr_pkg::MTU)) begin
          len_c  = '0;
          crc_c  = mdfr_pkg::CRC_INIT;
          l2_c   = 16'd0;
          ev_nxt = mdfr_pkg::EV_OVERFLOW;
        end
        if (len_c >= FW'(2)) begin
          crc_c = mdfr_pkg::crc_feed(crc_c, l2_c[15:8]);
        end
        if (len_c == '0) begin
          first_byte_nxt = in_tdata;
        end
        idx_nxt         = len_c[5:0];
        running_crc_nxt = crc_c;
        last_two_nxt    = {l2_c[7:0], in_tdata};
        frame_len_nxt   = len_c + FW'(1);
        dbyte_nxt       = in_tdata;
        if (ev_nxt == mdfr_pkg::EV_NONE) begin
          ev_nxt = mdfr_pkg::EV_STORED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_byte_r     <= mdfr_pkg::MARK_BYTE_RST;
      min_frame_len_r <= mdfr_pkg::MIN_FRAME_LEN_RST;
      timeout_ticks_r <= mdfr_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mdfr_pkg::REG_MARK_BYTE:     mark_byte_r     <= cfg_wdata;
        mdfr_pkg::REG_MIN_FRAME_LEN: min_frame_len_r <= cfg_wdata[6:0];
        mdfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_pending_r <= 1'b0;
      idle_flag_r    <= 1'b0;
      idle_ticks_r   <= 8'd0;
      frame_len_r    <= '0;
      running_crc_r  <= mdfr_pkg::CRC_INIT;
      last_two_r     <= 16'd0;
      first_byte_r   <= 8'd0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (accept) begin
        mark_pending_r <= mark_pending_nxt;
        idle_flag_r    <= idle_flag_nxt;
        idle_ticks_r   <= idle_ticks_nxt;
        frame_len_r    <= frame_len_nxt;
        running_crc_r  <= running_crc_nxt;
        last_two_r     <= last_two_nxt;
        first_byte_r   <= first_byte_nxt;
        out_tvalid_r   <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r    <= ev_nxt;
      dbyte_r <= dbyte_nxt;
      idx_r   <= idx_nxt;
      plen_r  <= plen_nxt;
      ftype_r <= ftype_nxt;
    end
  end

endmodule
